// File: sv/tafp_pkg.sv
// Package: shared types, codes and widths for the adaptation field parser
`timescale 1ns / 1ps
package tafp_pkg;

    localparam int unsigned IdW  = 4;
    localparam int unsigned ValW = 42;

    typedef enum logic [11:0] {
        SEC_FLAGS     = 12'h001,
        SEC_PCR       = 12'h002,
        SEC_OPCR      = 12'h004,
        SEC_COUNTDOWN = 12'h008,
        SEC_PRIVLEN   = 12'h010,
        SEC_PRIVSKIP  = 12'h020,
        SEC_EXTLEN    = 12'h040,
        SEC_EXTFLAGS  = 12'h080,
        SEC_LTW       = 12'h100,
        SEC_RATE      = 12'h200,
        SEC_SPLICE    = 12'h400,
        SEC_STUFF     = 12'h800
    } t_section;

    localparam logic [3:0] ID_LENGTH    = 4'd0;
    localparam logic [3:0] ID_FLAGS     = 4'd1;
    localparam logic [3:0] ID_PCR       = 4'd2;
    localparam logic [3:0] ID_OPCR      = 4'd3;
    localparam logic [3:0] ID_COUNTDOWN = 4'd4;
    localparam logic [3:0] ID_PRIVLEN   = 4'd5;
    localparam logic [3:0] ID_EXTLEN    = 4'd6;
    localparam logic [3:0] ID_EXTFLAGS  = 4'd7;
    localparam logic [3:0] ID_LTW       = 4'd8;
    localparam logic [3:0] ID_RATE      = 4'd9;
    localparam logic [3:0] ID_SPLICE    = 4'd10;
    localparam logic [3:0] ID_DTS       = 4'd11;
    localparam logic [3:0] ID_END       = 4'd12;

    // Work kinds handed from the front to the back
    typedef enum logic [1:0] {
        K_RAW   = 2'd0,
        K_CLOCK = 2'd1
    } t_kind;

    typedef struct packed {
        logic [3:0]  id;
        t_kind       kind;
        logic [47:0] payload;
        logic        last;
    } t_rec;

endpackage

// File: sv/tafp_front.sv
// Front: byte-wise section tracker that classifies completed fields
`timescale 1ns / 1ps
module tafp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_start_req,
    input  logic [7:0]      i_data_byte,
    output logic            o_rec_valid,
    input  logic            i_rec_ready,
    output tafp_pkg::t_rec  o_rec
);
    import tafp_pkg::*;

    logic        r_active;
    logic [7:0]  r_len;
    logic [7:0]  r_seen;
    t_section    r_sec;
    logic [2:0]  r_sb;
    logic [47:0] r_acc;
    logic [7:0]  r_iflags;
    logic [2:0]  r_xflags;
    logic [7:0]  r_skip;

    logic        n_active;
    logic [7:0]  n_len;
    logic [7:0]  n_seen;
    t_section    n_sec;
    logic [2:0]  n_sb;
    logic [47:0] n_acc;
    logic [7:0]  n_iflags;
    logic [2:0]  n_xflags;
    logic [7:0]  n_skip;

    logic        emit;
    t_rec        rec;
    logic        take;
    logic [2:0]  sb1;
    logic [47:0] acc1;
    logic        adv;
    t_section    adv_from;

    function automatic logic en(input t_section s, input logic [7:0] f,
                                input logic [2:0] x, input logic [7:0] sk);
        logic r;
        r = 1'b1;
        unique case (s)
            SEC_PCR:       r = f[4];
            SEC_OPCR:      r = f[3];
            SEC_COUNTDOWN: r = f[2];
            SEC_PRIVLEN:   r = f[1];
            SEC_PRIVSKIP:  r = (sk != 8'd0);
            SEC_EXTLEN,
            SEC_EXTFLAGS:  r = f[0];
            SEC_LTW:       r = x[2];
            SEC_RATE:      r = x[1];
            SEC_SPLICE:    r = x[0];
            default:       r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic t_section succ(input t_section s);
        t_section r;
        r = SEC_STUFF;
        unique case (s)
            SEC_FLAGS:     r = SEC_PCR;
            SEC_PCR:       r = SEC_OPCR;
            SEC_OPCR:      r = SEC_COUNTDOWN;
            SEC_COUNTDOWN: r = SEC_PRIVLEN;
            SEC_PRIVLEN:   r = SEC_PRIVSKIP;
            SEC_PRIVSKIP:  r = SEC_EXTLEN;
            SEC_EXTLEN:    r = SEC_EXTFLAGS;
            SEC_EXTFLAGS:  r = SEC_LTW;
            SEC_LTW:       r = SEC_RATE;
            SEC_RATE:      r = SEC_SPLICE;
            default:       r = SEC_STUFF;
        endcase
        return r;
    endfunction

    function automatic t_section nxt(input t_section s, input logic [7:0] f,
                                     input logic [2:0] x, input logic [7:0] sk);
        t_section r;
        r = succ(s);
        for (int i = 0; i < 10; i++) begin
            if (r != SEC_STUFF && !en(r, f, x, sk)) begin
                r = succ(r);
            end
        end
        return r;
    endfunction

    assign o_ready     = !o_rec_valid || i_rec_ready;
    assign take        = i_valid && o_ready;

    always_comb begin
        n_active = r_active;
        n_len    = r_len;
        n_seen   = r_seen;
        n_sec    = r_sec;
        n_sb     = r_sb;
        n_acc    = r_acc;
        n_iflags = r_iflags;
        n_xflags = r_xflags;
        n_skip   = r_skip;
        emit     = 1'b0;
        rec      = '{id: ID_LENGTH, kind: K_RAW, payload: 48'd0, last: 1'b0};
        sb1      = r_sb + 3'd1;
        acc1     = {r_acc[39:0], i_data_byte};
        adv      = 1'b0;
        adv_from = r_sec;
        if (i_start_req) begin
            n_active = (i_data_byte != 8'd0);
            n_len    = i_data_byte;
            n_seen   = 8'd0;
            n_sec    = SEC_FLAGS;
            n_sb     = 3'd0;
            n_acc    = 48'd0;
            n_iflags = 8'd0;
            n_xflags = 3'd0;
            n_skip   = 8'd0;
            emit     = 1'b1;
            rec      = '{id: ID_LENGTH, kind: K_RAW, payload: {40'd0, i_data_byte},
                         last: (i_data_byte == 8'd0)};
        end else if (r_active) begin
            n_seen = r_seen + 8'd1;
            n_acc  = acc1;
            n_sb   = sb1;
            rec.payload = {40'd0, i_data_byte};
            unique case (r_sec)
                SEC_FLAGS: begin
                    n_iflags = i_data_byte;
                    emit = 1'b1; rec.id = ID_FLAGS; adv = 1'b1;
                end
                SEC_PCR, SEC_OPCR: begin
                    if (sb1 == 3'd6) begin
                        emit = 1'b1;
                        rec.id = (r_sec == SEC_PCR) ? ID_PCR : ID_OPCR;
                        rec.kind = K_CLOCK;
                        rec.payload = acc1;
                        adv = 1'b1;
                    end
                end
                SEC_COUNTDOWN: begin
                    emit = 1'b1; rec.id = ID_COUNTDOWN; adv = 1'b1;
                end
                SEC_PRIVLEN: begin
                    n_skip = i_data_byte;
                    emit = 1'b1; rec.id = ID_PRIVLEN;
                    if (i_data_byte != 8'd0) begin
                        n_sec = SEC_PRIVSKIP; n_sb = 3'd0; n_acc = 48'd0;
                    end else begin
                        adv = 1'b1; adv_from = SEC_PRIVSKIP;
                    end
                end
                SEC_PRIVSKIP: begin
                    n_skip = r_skip - 8'd1;
                    if (n_skip == 8'd0) begin
                        adv = 1'b1;
                    end
                end
                SEC_EXTLEN: begin
                    emit = 1'b1; rec.id = ID_EXTLEN; adv = 1'b1;
                end
                SEC_EXTFLAGS: begin
                    n_xflags = i_data_byte[7:5];
                    emit = 1'b1; rec.id = ID_EXTFLAGS; adv = 1'b1;
                end
                SEC_LTW: begin
                    if (sb1 == 3'd2) begin
                        emit = 1'b1; rec.id = ID_LTW;
                        rec.payload = {32'd0, acc1[15:0]}; adv = 1'b1;
                    end
                end
                SEC_RATE: begin
                    if (sb1 == 3'd3) begin
                        emit = 1'b1; rec.id = ID_RATE;
                        rec.payload = {26'd0, acc1[21:0]}; adv = 1'b1;
                    end
                end
                SEC_SPLICE: begin
                    if (sb1 == 3'd1) begin
                        emit = 1'b1; rec.id = ID_SPLICE;
                        rec.payload = {44'd0, i_data_byte[7:4]};
                    end else if (sb1 == 3'd5) begin
                        emit = 1'b1; rec.id = ID_DTS;
                        rec.payload = {15'd0, acc1[35:33], acc1[31:17], acc1[15:1]};
                        adv = 1'b1;
                    end
                end
                default: n_sec = SEC_STUFF;
            endcase
            if (adv) begin
                n_sec = nxt(adv_from, n_iflags, n_xflags, n_skip);
                n_sb  = 3'd0;
                n_acc = 48'd0;
            end
            if (n_seen == r_len) begin
                n_active = 1'b0;
                rec.last = 1'b1;
                if (!emit) begin
                    emit = 1'b1;
                    rec  = '{id: ID_END, kind: K_RAW, payload: 48'd0, last: 1'b1};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_len       <= 8'd0;
            r_seen      <= 8'd0;
            r_sec       <= SEC_FLAGS;
            r_sb        <= 3'd0;
            r_acc       <= 48'd0;
            r_iflags    <= 8'd0;
            r_xflags    <= 3'd0;
            r_skip      <= 8'd0;
            o_rec_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                o_rec_valid <= take && emit;
            end
            if (take) begin
                r_active <= n_active;
                r_len    <= n_len;
                r_seen   <= n_seen;
                r_sec    <= n_sec;
                r_sb     <= n_sb;
                r_acc    <= n_acc;
                r_iflags <= n_iflags;
                r_xflags <= n_xflags;
                r_skip   <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            o_rec <= rec;
        end
    end

endmodule

// File: sv/tafp_fifo.sv
// Short queue between the front and the back
`timescale 1ns / 1ps
module tafp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  tafp_pkg::t_rec  i_rec,
    output logic            o_valid,
    input  logic            i_ready,
    output tafp_pkg::t_rec  o_rec
);
    import tafp_pkg::*;

    t_rec       r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_rec   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

endmodule

// File: sv/tafp_back.sv
// Back: two-stage clock value arithmetic and output register
`timescale 1ns / 1ps
module tafp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tafp_pkg::t_rec              i_rec,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [tafp_pkg::IdW-1:0]    o_id,
    output logic [tafp_pkg::ValW-1:0]   o_value,
    output logic                        o_last
);
    import tafp_pkg::*;

    logic        r_v1;
    logic [3:0]  r_id1;
    logic        r_last1;
    logic        r_clk1;
    logic [41:0] r_prod1;
    logic [8:0]  r_ext1;
    logic [41:0] r_raw1;
    logic        adv1;
    logic        adv2;
    logic [41:0] val2;

    assign adv2    = !o_valid || i_ready;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign val2    = r_clk1 ? (r_prod1 + {33'd0, r_ext1}) : r_raw1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                o_valid <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_valid) begin
            r_id1   <= i_rec.id;
            r_last1 <= i_rec.last;
            r_clk1  <= (i_rec.kind == K_CLOCK);
            r_prod1 <= 42'(i_rec.payload[47:15] * 42'd300);
            r_ext1  <= i_rec.payload[8:0];
            r_raw1  <= i_rec.payload[41:0];
        end
        if (adv2 && r_v1) begin
            o_id    <= r_id1;
            o_value <= val2;
            o_last  <= r_last1;
        end
    end

endmodule

// File: sv/ts_adaptation_field_parser_top.sv
// Top level: adaptation field parser, byte stream in, field records out
// An accepted byte's record passes the front's output register, the queue and the back's two registers.
// Throughput: one byte per cycle while the output side takes records; the section tracker in the front sets it.
// A four-entry queue lets the front run while the output is stalled.
// Reset (synchronous, active low) returns to idle and empties all stages.
`timescale 1ns / 1ps
module ts_adaptation_field_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [41:0] value, zero fill
    output logic [3:0]  m_axis_tuser,   // [3:0] field_id
    output logic        m_axis_tlast
);
    import tafp_pkg::*;

    logic                f_valid;
    logic                f_ready;
    t_rec                f_rec;
    logic                q_valid;
    logic                q_ready;
    t_rec                q_rec;
    logic [IdW-1:0]      id;
    logic [ValW-1:0]     val;

    tafp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_start_req (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .o_rec_valid (f_valid),
        .i_rec_ready (f_ready),
        .o_rec       (f_rec)
    );

    tafp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_rec   (f_rec),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_rec   (q_rec)
    );

    tafp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_rec   (q_rec),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_id    (id),
        .o_value (val),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, val};
    assign m_axis_tuser = id;

endmodule
